@@ rtl/bitmap_page_allocator_macros.svh @@
// Assertion macros shared by the page allocator modules.
`ifndef BITMAP_PAGE_ALLOCATOR_MACROS_SVH
`define BITMAP_PAGE_ALLOCATOR_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define BPA_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bitmap page allocator: check failed");

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define BPA_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bitmap page allocator: check failed");

`endif

@@ rtl/bpa_pkg.sv @@
// Types and codes shared by the page allocator controller and datapath.
package bpa_pkg;

    localparam int FREE_BYTES_W = 28;
    localparam logic [FREE_BYTES_W-1:0] FREE_BYTES_MAX = 28'hFFFFFFF;

    localparam logic [0:0] REG_RAM_BASE   = 1'b0;
    localparam logic [0:0] REG_KERNEL_END = 1'b1;

    typedef enum logic [1:0] {
        CMD_INIT  = 2'd0,
        CMD_ALLOC = 2'd1,
        CMD_FREE  = 2'd2
    } cmd_t;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_OUT_OF_MEM  = 3'd1,
        ST_NOT_FOUND   = 3'd2,
        ST_OUT_OF_BNDS = 3'd3,
        ST_MISALIGNED  = 3'd4,
        ST_DOUBLE_FREE = 3'd5
    } status_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_INIT_CALC,
        S_INIT_FILL,
        S_ALLOC_RD,
        S_ALLOC_CHK,
        S_FREE_RD,
        S_FREE_CHK,
        S_DONE
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    ld_item;
        logic    calc_end;
        logic    calc_kp;
        logic    wcnt_clr;
        logic    wcnt_hint;
        logic    wcnt_idx;
        logic    fill_wr;
        logic    init_commit;
        logic    rd_issue;
        logic    alloc_step;
        logic    free_commit;
        logic    set_res;
        status_t res_code;
        logic    out_load;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        cmd_t item_cmd;
        logic fc_zero;
        logic hint_end;
        logic free_oob;
        logic free_mis;
        logic bit_set;
        logic found;
        logic last_word;
    } dp_stat_t;

endpackage

@@ rtl/bpa_dp.sv @@
// Allocator datapath: bitmap memory, counters, address checks and result registers.
`include "bitmap_page_allocator_macros.svh"

module bpa_dp #(
    parameter int PAGES      = 32768,
    parameter int PAGE_BYTES = 4096
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [0:0]                           cfg_index,
    input  logic [31:0]                          cfg_data,
    input  logic [1:0]                           cmd,
    input  logic [31:0]                          free_address,
    input  bpa_pkg::dp_cmd_t                     ctl,
    output bpa_pkg::dp_stat_t                    st,
    output logic [2:0]                           status,
    output logic [31:0]                          page_address,
    output logic [bpa_pkg::FREE_BYTES_W-1:0]     free_bytes
);
    import bpa_pkg::*;

    localparam int MAP_WORDS = (PAGES + 31) / 32;
    localparam int WA_W      = $clog2(MAP_WORDS);
    localparam int PG_W      = $clog2(PAGES + 1);
    localparam int IDX_W     = $clog2(PAGES);
    localparam int PB_LOG    = $clog2(PAGE_BYTES);
    localparam int LAST_BITS = PAGES - (MAP_WORDS - 1) * 32;
    localparam int CW        = WA_W + PG_W;
    localparam int FBX_W     = PG_W + PB_LOG;
    localparam int FBC_W     = (FBX_W > FREE_BYTES_W) ? FBX_W : FREE_BYTES_W;
    localparam longint unsigned SPAN = longint'(PAGES) * longint'(PAGE_BYTES);
    localparam logic [WA_W-1:0] LAST_WORD = WA_W'(MAP_WORDS - 1);

    logic [31:0]          mem [MAP_WORDS];

    logic [31:0]          base_reg;
    logic [31:0]          kend_reg;
    cmd_t                 item_cmd_reg;
    logic [31:0]          item_addr_reg;
    logic [32:0]          end_reg;
    logic [PG_W-1:0]      kp_reg;
    logic [PG_W-1:0]      fc_reg, fc_next;
    logic [PG_W-1:0]      hint_reg, hint_next;
    logic [WA_W-1:0]      wcnt_reg, wcnt_next;
    logic [31:0]          rd_data_reg;
    status_t              res_reg;
    logic [31:0]          pa_reg;
    logic [2:0]           status_reg;
    logic [31:0]          page_address_reg;
    logic [FREE_BYTES_W-1:0] free_bytes_reg;

    logic [31:0]          off;
    logic [IDX_W-1:0]     free_idx;
    logic [36:0]          top;
    logic                 oob;
    logic                 mis;
    logic [WA_W-1:0]      hint_word;
    logic [31:0]          lo_mask;
    logic [31:0]          hi_mask;
    logic [31:0]          avail;
    logic                 found;
    logic [4:0]           bsel;
    logic [IDX_W-1:0]     hit_idx;
    logic                 alloc_hit;
    logic [31:0]          pa_hit;
    logic [CW-1:0]        wbase;
    logic [CW-1:0]        kpx;
    logic [31:0]          fill_word;
    logic [32:0]          end_sum;
    logic [32:0]          diff;
    logic [32:0]          pages_raw;
    logic [PG_W-1:0]      kp_calc;
    logic [FBC_W-1:0]     fbc;
    logic [FREE_BYTES_W-1:0] fb_calc;
    logic                 wr_en;
    logic [31:0]          wr_data;

    // Free addr checks; item regs hold; config regs: user holds in item, unenforced.
    assign off      = item_addr_reg - base_reg;
    assign free_idx = IDX_W'(off >> PB_LOG);
    assign top      = {5'd0, base_reg} + 37'(SPAN);
    assign oob      = (item_addr_reg < base_reg) || ({5'd0, item_addr_reg} >= top);
    assign mis      = |item_addr_reg[PB_LOG-1:0];

    // Word scan: pages below the hint and past the last page count as used.
    assign hint_word = WA_W'(hint_reg >> 5);
    assign lo_mask   = (wcnt_reg == hint_word) ? ~(32'hFFFFFFFF << hint_reg[4:0]) : 32'd0;
    assign hi_mask   = (wcnt_reg == LAST_WORD) ? (32'hFFFFFFFF << LAST_BITS) : 32'd0;
    assign avail     = ~(rd_data_reg | lo_mask | hi_mask);
    assign found     = |avail;

    always_comb
    begin
        bsel = 5'd0;
        for (int b = 31; b >= 0; b--)
        begin
            if (avail[b])
            begin
                bsel = 5'(b);
            end
        end
    end

    assign hit_idx   = IDX_W'({wcnt_reg, bsel});
    assign alloc_hit = ctl.alloc_step && found;
    assign pa_hit    = base_reg + (32'(hit_idx) << PB_LOG);

    // Init pattern for the word under the counter: pages below kp are set.
    assign wbase = CW'({wcnt_reg, 5'd0});
    assign kpx   = CW'(kp_reg);

    always_comb
    begin
        if (kpx >= wbase + CW'(32))
        begin
            fill_word = 32'hFFFFFFFF;
        end
        else if (kpx > wbase)
        begin
            fill_word = ~(32'hFFFFFFFF << kp_reg[4:0]);
        end
        else
        begin
            fill_word = 32'd0;
        end
    end

    assign end_sum   = 33'(kend_reg) + 33'(PAGE_BYTES - 1);
    assign diff      = end_reg - 33'(base_reg);
    assign pages_raw = diff >> PB_LOG;

    always_comb
    begin
        if (end_reg <= 33'(base_reg))
        begin
            kp_calc = '0;
        end
        else if (pages_raw > 33'(PAGES))
        begin
            kp_calc = PG_W'(PAGES);
        end
        else
        begin
            kp_calc = PG_W'(pages_raw);
        end
    end

    assign fbc     = FBC_W'(fc_reg) << PB_LOG;
    assign fb_calc = (fbc > FBC_W'(FREE_BYTES_MAX)) ? FREE_BYTES_MAX
                                                     : fbc[FREE_BYTES_W-1:0];

    always_comb
    begin
        wcnt_next = wcnt_reg;
        if (ctl.wcnt_clr)
        begin
            wcnt_next = '0;
        end
        else if (ctl.wcnt_hint)
        begin
            wcnt_next = hint_word;
        end
        else if (ctl.wcnt_idx)
        begin
            wcnt_next = WA_W'(free_idx >> 5);
        end
        else if (ctl.fill_wr || (ctl.alloc_step && !found))
        begin
            wcnt_next = wcnt_reg + 1'b1;
        end
    end

    always_comb
    begin
        fc_next   = fc_reg;
        hint_next = hint_reg;
        if (ctl.init_commit)
        begin
            fc_next   = PG_W'(PAGES) - kp_reg;
            hint_next = kp_reg;
        end
        else if (alloc_hit)
        begin
            fc_next   = fc_reg - 1'b1;
            hint_next = PG_W'(hit_idx) + 1'b1;
        end
        else if (ctl.free_commit)
        begin
            fc_next = fc_reg + 1'b1;
            if (PG_W'(free_idx) < hint_reg)
            begin
                hint_next = PG_W'(free_idx);
            end
        end
    end

    always_comb
    begin
        wr_en   = 1'b0;
        wr_data = fill_word;
        if (ctl.fill_wr)
        begin
            wr_en = 1'b1;
        end
        else if (alloc_hit)
        begin
            wr_en   = 1'b1;
            wr_data = rd_data_reg | (32'd1 << bsel);
        end
        else if (ctl.free_commit)
        begin
            wr_en   = 1'b1;
            wr_data = rd_data_reg & ~(32'd1 << free_idx[4:0]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wcnt_reg] <= wr_data;
        end
        if (ctl.rd_issue)
        begin
            rd_data_reg <= mem[wcnt_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= 32'h40000000;
            kend_reg <= 32'h40000000;
            kp_reg   <= '0;
            fc_reg   <= PG_W'(PAGES);
            hint_reg <= '0;
            wcnt_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_RAM_BASE:   base_reg <= cfg_data;
                    REG_KERNEL_END: kend_reg <= cfg_data;
                    default:        ;
                endcase
            end
            if (ctl.calc_kp)
            begin
                kp_reg <= kp_calc;
            end
            fc_reg   <= fc_next;
            hint_reg <= hint_next;
            wcnt_reg <= wcnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.ld_item)
        begin
            item_cmd_reg  <= cmd_t'(cmd);
            item_addr_reg <= free_address;
        end
        if (ctl.calc_end)
        begin
            end_reg <= end_sum & ~33'(PAGE_BYTES - 1);
        end
        // A successful alloc always sets its result in the same cycle.
        if (ctl.set_res)
        begin
            res_reg <= ctl.res_code;
            pa_reg  <= alloc_hit ? pa_hit : 32'd0;
        end
        if (ctl.out_load)
        begin
            status_reg       <= res_reg;
            page_address_reg <= pa_reg;
            free_bytes_reg   <= fb_calc;
        end
    end

    assign st.item_cmd  = item_cmd_reg;
    assign st.fc_zero   = (fc_reg == '0);
    assign st.hint_end  = (hint_reg >= PG_W'(PAGES));
    assign st.free_oob  = oob;
    assign st.free_mis  = mis;
    assign st.bit_set   = rd_data_reg[free_idx[4:0]];
    assign st.found     = found;
    assign st.last_word = (wcnt_reg == LAST_WORD);

    assign status       = status_reg;
    assign page_address = page_address_reg;
    assign free_bytes   = free_bytes_reg;

    `BPA_ASSERT_NEXT(a_alloc_takes_one, alloc_hit, fc_reg == $past(fc_reg) - 1'b1)
    `BPA_ASSERT_IMP(a_free_only_used, ctl.free_commit, rd_data_reg[free_idx[4:0]])

endmodule

@@ rtl/bpa_ctrl.sv @@
// Allocator controller: sequences clear, init, alloc and free over the datapath.
`include "bitmap_page_allocator_macros.svh"

module bpa_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    output logic              out_valid,
    input  logic              out_stall,
    input  bpa_pkg::dp_stat_t st,
    output bpa_pkg::dp_cmd_t  ctl
);
    import bpa_pkg::*;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    // The result register can take a new item when empty or being drained.
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (st.last_word)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                case (st.item_cmd)
                    CMD_INIT:
                    begin
                        state_next = S_INIT_CALC;
                    end
                    CMD_ALLOC:
                    begin
                        if (st.fc_zero || st.hint_end)
                        begin
                            state_next = S_DONE;
                        end
                        else
                        begin
                            state_next = S_ALLOC_RD;
                        end
                    end
                    CMD_FREE:
                    begin
                        if (st.free_oob || st.free_mis)
                        begin
                            state_next = S_DONE;
                        end
                        else
                        begin
                            state_next = S_FREE_RD;
                        end
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_INIT_CALC:
            begin
                state_next = S_INIT_FILL;
            end
            S_INIT_FILL:
            begin
                if (st.last_word)
                begin
                    state_next = S_DONE;
                end
            end
            S_ALLOC_RD:
            begin
                state_next = S_ALLOC_CHK;
            end
            S_ALLOC_CHK:
            begin
                if (st.found || st.last_word)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_ALLOC_RD;
                end
            end
            S_FREE_RD:
            begin
                state_next = S_FREE_CHK;
            end
            S_FREE_CHK:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ctl            = '0;
        ctl.res_code   = ST_OK;
        out_valid_next = out_valid_reg && out_stall;
        case (state_reg)
            S_CLEAR:
            begin
                ctl.fill_wr = 1'b1;
            end
            S_IDLE:
            begin
                ctl.ld_item = in_valid;
            end
            S_DECODE:
            begin
                case (st.item_cmd)
                    CMD_INIT:
                    begin
                        ctl.calc_end = 1'b1;
                    end
                    CMD_ALLOC:
                    begin
                        if (st.fc_zero)
                        begin
                            ctl.set_res  = 1'b1;
                            ctl.res_code = ST_OUT_OF_MEM;
                        end
                        else if (st.hint_end)
                        begin
                            ctl.set_res  = 1'b1;
                            ctl.res_code = ST_NOT_FOUND;
                        end
                        else
                        begin
                            ctl.wcnt_hint = 1'b1;
                        end
                    end
                    CMD_FREE:
                    begin
                        if (st.free_oob)
                        begin
                            ctl.set_res  = 1'b1;
                            ctl.res_code = ST_OUT_OF_BNDS;
                        end
                        else if (st.free_mis)
                        begin
                            ctl.set_res  = 1'b1;
                            ctl.res_code = ST_MISALIGNED;
                        end
                        else
                        begin
                            ctl.wcnt_idx = 1'b1;
                        end
                    end
                    default:
                    begin
                        ctl.set_res = 1'b1;
                    end
                endcase
            end
            S_INIT_CALC:
            begin
                ctl.calc_kp  = 1'b1;
                ctl.wcnt_clr = 1'b1;
            end
            S_INIT_FILL:
            begin
                ctl.fill_wr = 1'b1;
                if (st.last_word)
                begin
                    ctl.init_commit = 1'b1;
                    ctl.set_res     = 1'b1;
                end
            end
            S_ALLOC_RD, S_FREE_RD:
            begin
                ctl.rd_issue = 1'b1;
            end
            S_ALLOC_CHK:
            begin
                ctl.alloc_step = 1'b1;
                if (st.found)
                begin
                    ctl.set_res = 1'b1;
                end
                else if (st.last_word)
                begin
                    ctl.set_res  = 1'b1;
                    ctl.res_code = ST_NOT_FOUND;
                end
            end
            S_FREE_CHK:
            begin
                ctl.set_res = 1'b1;
                if (st.bit_set)
                begin
                    ctl.free_commit = 1'b1;
                end
                else
                begin
                    ctl.res_code = ST_DOUBLE_FREE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    ctl.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    `BPA_ASSERT_NEXT(a_accept_decodes, in_valid && !in_stall, state_reg == S_DECODE)
    `BPA_ASSERT_NEXT(a_result_held, out_valid_reg && out_stall, out_valid_reg)
    `BPA_ASSERT_NEXT(a_scan_continues, state_reg == S_ALLOC_CHK && !st.found && !st.last_word,
                     state_reg == S_ALLOC_RD)

endmodule

@@ rtl/bitmap_page_allocator.sv @@
// Top level of the bitmap page allocator: controller plus datapath.
//
//   channel   handshake            payload
//   -------   ------------------   -----------------------------------
//   config    cfg_we               cfg_index, cfg_data
//   input     in_valid / in_stall  cmd, free_address
//   output    out_valid/out_stall  status, page_address, free_bytes
//
// After reset a clearing pass writes every bitmap word while in_stall stays high;
// config writes are taken meanwhile. Items are taken one at a time. Init writes
// one bitmap word per cycle; alloc scans words from the hint, with one read and one
// check of the single-port bitmap each; free reads the word of its page. A free
// that is out of bounds or misaligned, an alloc that fails at once and an unused
// command go straight to the result register.
// A stalled result is held; the next item is taken once it is in the output register.

module bitmap_page_allocator #(
    parameter int PAGES      = 32768,
    parameter int PAGE_BYTES = 4096
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  cmd,
    input  logic [31:0] free_address,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  status,
    output logic [31:0] page_address,
    output logic [27:0] free_bytes
);
    import bpa_pkg::*;

    dp_cmd_t  ctl;
    dp_stat_t st;

    bpa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .st        (st),
        .ctl       (ctl)
    );

    bpa_dp #(
        .PAGES      (PAGES),
        .PAGE_BYTES (PAGE_BYTES)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cmd          (cmd),
        .free_address (free_address),
        .ctl          (ctl),
        .st           (st),
        .status       (status),
        .page_address (page_address),
        .free_bytes   (free_bytes)
    );

endmodule
